// File: hw/rtl/ppf_pkg.sv
package ppf_pkg;

   // count fields cover window sizes up to 64
   localparam int CNT_W = 7;
   localparam int LA_W  = 8;

   localparam logic [2:0] REG_WIDTH_LEFT      = 3'd0;
   localparam logic [2:0] REG_WIDTH_RIGHT     = 3'd1;
   localparam logic [2:0] REG_MONOTONIC_SPAN  = 3'd2;
   localparam logic [2:0] REG_PROM_THRESHOLD  = 3'd3;
   localparam logic [2:0] REG_SEARCH_LEFT     = 3'd4;
   localparam logic [2:0] REG_SEARCH_RIGHT    = 3'd5;
   localparam logic [2:0] REG_FLOOR_BOUND     = 3'd6;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_START = 5'b00010,
      S_SCAN  = 5'b00100,
      S_EMIT  = 5'b01000,
      S_FIN   = 5'b10000
   } state_type;

   typedef struct packed {
      logic        [CNT_W-1:0] wl;
      logic        [CNT_W-1:0] wr;
      logic        [CNT_W-1:0] ds;
      logic        [CNT_W-1:0] sl;
      logic        [CNT_W-1:0] sr;
      logic        [15:0]      thr;
      logic signed [15:0]      floor_b;
      logic signed [LA_W-1:0]  la;
      logic        [CNT_W-1:0] ra;
   } judge_cfg_type;

endpackage

// File: hw/rtl/ppf_cell.sv
module ppf_cell import ppf_pkg::*; #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          clear,
   input  logic                          shift_en,
   input  logic signed [SAMPLE_BITS-1:0] d_in,
   output logic signed [SAMPLE_BITS-1:0] q
);

   logic signed [SAMPLE_BITS-1:0] q_ff;

   always_ff @(posedge clock) begin
      if (clear) begin
         q_ff <= '0;
      end else if (shift_en) begin
         q_ff <= d_in;
      end
   end

   assign q = q_ff;

endmodule

// File: hw/rtl/ppf_judge.sv
module ppf_judge import ppf_pkg::*; #(
   parameter int WINDOW_MAX  = 32,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  judge_cfg_type                 cfg,
   input  logic signed [SAMPLE_BITS-1:0] win [2*WINDOW_MAX+2],
   output logic                          done,
   output logic                          peak,
   output logic [SAMPLE_BITS:0]          prom
);

   localparam int DEPTH = 2 * WINDOW_MAX + 2;
   localparam int C     = WINDOW_MAX + 1;
   localparam int LEN   = WINDOW_MAX + 1;
   localparam int PRW   = SAMPLE_BITS + 1;
   localparam int TW    = (PRW > 16) ? PRW : 16;
   localparam int FW    = ((SAMPLE_BITS > 16) ? SAMPLE_BITS : 16) + 1;
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(WINDOW_MAX + 1);
   localparam logic [CNT_W-1:0] FIN_STEP  = CNT_W'(WINDOW_MAX + 2);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [CNT_W-1:0]              step_ff, step_in;
   logic signed [SAMPLE_BITS-1:0] lch_ff [LEN];
   logic signed [SAMPLE_BITS-1:0] lch_in [LEN];
   logic signed [SAMPLE_BITS-1:0] rch_ff [LEN];
   logic signed [SAMPLE_BITS-1:0] rch_in [LEN];
   logic signed [SAMPLE_BITS-1:0] pk_ff, pk_in;
   logic signed [SAMPLE_BITS-1:0] lprev_ff, lprev_in;
   logic signed [SAMPLE_BITS-1:0] lmin_ff, lmin_in;
   logic signed [SAMPLE_BITS-1:0] rmin_ff, rmin_in;
   logic                          lgo_ff, lgo_in;
   logic                          rgo_ff, rgo_in;
   logic                          fail_ff, fail_in;
   logic                          peak_ff, peak_in;
   logic [PRW-1:0]                prom_ff, prom_in;

   logic [CNT_W-1:0]              mw;
   logic signed [LA_W-1:0]        d_s;
   logic signed [SAMPLE_BITS-1:0] lv, rv, r1, mn;
   logic signed [PRW-1:0]         diff;
   logic                          below;

   always_comb begin
      mw    = (cfg.wl > cfg.wr) ? cfg.wl : cfg.wr;
      d_s   = LA_W'(step_ff);
      lv    = lch_ff[0];
      rv    = rch_ff[0];
      r1    = rch_ff[1];
      mn    = (lmin_ff < rmin_ff) ? lmin_ff : rmin_ff;
      below = FW'(mn) < FW'(cfg.floor_b);
      diff  = PRW'(pk_ff) - PRW'(mn);

      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      lch_in   = lch_ff;
      rch_in   = rch_ff;
      pk_in    = pk_ff;
      lprev_in = lprev_ff;
      lmin_in  = lmin_ff;
      rmin_in  = rmin_ff;
      lgo_in   = lgo_ff;
      rgo_in   = rgo_ff;
      fail_in  = fail_ff;
      peak_in  = peak_ff;
      prom_in  = prom_ff;

      if (start) begin
         busy_in  = 1'b1;
         step_in  = CNT_W'(1);
         pk_in    = win[C];
         lprev_in = win[C];
         lmin_in  = win[C];
         rmin_in  = win[C];
         lgo_in   = cfg.la >= LA_W'(1);
         rgo_in   = 1'b1;
         fail_in  = (cfg.la < $signed(LA_W'(mw))) || (cfg.ra < mw);
         for (int i = 0; i < LEN; i++) begin
            lch_in[i] = win[C-1-i];
         end
         for (int i = 0; i < LEN - 1; i++) begin
            rch_in[i] = win[C+1+i];
         end
         rch_in[LEN-1] = '0;
      end else if (busy_ff) begin
         if (step_ff == FIN_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            prom_in = below ? '0 : diff;
            peak_in = !fail_ff && (TW'(prom_in) >= TW'(cfg.thr));
         end else begin
            // neighbourhood maximum
            if (step_ff <= cfg.wl && lv > pk_ff) fail_in = 1'b1;
            if (step_ff <= cfg.wr && rv > pk_ff) fail_in = 1'b1;
            // rise and fall around the candidate
            if (step_ff <= cfg.ds && d_s <= cfg.la && lv > lprev_ff) fail_in = 1'b1;
            if (step_ff <= cfg.ds && ({1'b0, step_ff} + 1'b1) <= {1'b0, cfg.ra} && rv < r1)
               fail_in = 1'b1;
            // left search takes the sample that stops it
            if (lgo_ff) begin
               if (lv < lmin_ff && lv != '0) lmin_in = lv;
               lgo_in = (d_s < cfg.la) && (lv < pk_ff) && (step_ff <= cfg.sl);
            end
            if (rgo_ff && step_ff <= cfg.ra && rv < pk_ff && step_ff <= cfg.sr) begin
               if (rv < rmin_ff && rv != '0) rmin_in = rv;
            end else begin
               rgo_in = 1'b0;
            end
            lprev_in = lv;
            for (int i = 0; i < LEN - 1; i++) begin
               lch_in[i] = lch_ff[i+1];
               rch_in[i] = rch_ff[i+1];
            end
            lch_in[LEN-1] = '0;
            rch_in[LEN-1] = '0;
            step_in = step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      lch_ff   <= lch_in;
      rch_ff   <= rch_in;
      pk_ff    <= pk_in;
      lprev_ff <= lprev_in;
      lmin_ff  <= lmin_in;
      rmin_ff  <= rmin_in;
      lgo_ff   <= lgo_in;
      rgo_ff   <= rgo_in;
      fail_ff  <= fail_in;
      peak_ff  <= peak_in;
      prom_ff  <= prom_in;
   end

   assign done = done_ff;
   assign peak = peak_ff;
   assign prom = prom_ff;

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (step_ff >= CNT_W'(1) && step_ff <= FIN_STEP))
      else $error("scan step out of range");
   a_done_ends_scan: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("done raised while scan still running");
   a_mins_bounded: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && step_ff != LAST_STEP && step_ff != FIN_STEP)
         |-> (lmin_ff <= pk_ff && rmin_ff <= pk_ff))
      else $error("side minimum above peak");

endmodule

// File: hw/rtl/prominence_peak_finder.sv
// a sample's result follows the beat through load, WINDOW_MAX+1 scan steps through the
// cell chains, finish, hand-off and emit
// a new sample is taken only once the block has finished with the previous one
// the final sample judges WINDOW_MAX+1 positions, then issues the end of wave beat;
// a held result beat stalls the scan until it is taken
// reset is synchronous: window and count cleared, registers to their defaults
module prominence_peak_finder import ppf_pkg::*; #(
   parameter int WINDOW_MAX  = 32,
   parameter int MAX_SAMPLES = 8192,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [SAMPLE_BITS-1:0]          req_sample,
   input  logic                                   req_is_last,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_peak_valid,
   output logic [$clog2(MAX_SAMPLES)-1:0]         rsp_peak_index,
   output logic signed [SAMPLE_BITS-1:0]          rsp_peak_height,
   output logic [15:0]                            rsp_peak_prominence,
   output logic                                   rsp_end_of_wave,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [2:0]                             csr_index,
   input  logic [15:0]                            csr_data
);

   localparam int DEPTH = 2 * WINDOW_MAX + 2;
   localparam int C     = WINDOW_MAX + 1;
   localparam int IW    = $clog2(MAX_SAMPLES);
   localparam int PRW   = SAMPLE_BITS + 1;
   localparam int TW    = (PRW > 16) ? PRW : 16;
   localparam logic [IW-1:0]          P_MAX  = IW'(MAX_SAMPLES - 1);
   localparam logic signed [LA_W-1:0] LA_MAX = LA_W'(WINDOW_MAX + 1);

   state_type state_ff, state_in;

   logic [5:0]         width_left_ff, width_right_ff, search_left_ff, search_right_ff;
   logic [4:0]         mono_ff;
   logic [15:0]        thr_ff;
   logic signed [15:0] floor_ff;

   logic [IW-1:0]          p_ff, p_in;
   logic [IW-1:0]          pos_ff, pos_in;
   logic signed [LA_W-1:0] la_ff, la_in;
   logic [CNT_W-1:0]       ra_ff, ra_in;
   logic                   last_ff, last_in;

   logic                          pend_v_ff, pend_v_in;
   logic [IW-1:0]                 pend_idx_ff, pend_idx_in;
   logic signed [SAMPLE_BITS-1:0] pend_h_ff, pend_h_in;
   logic [15:0]                   pend_p_ff, pend_p_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_pv_ff, rsp_pv_in;
   logic [IW-1:0]                 rsp_idx_ff, rsp_idx_in;
   logic signed [SAMPLE_BITS-1:0] rsp_h_ff, rsp_h_in;
   logic [15:0]                   rsp_p_ff, rsp_p_in;
   logic                          rsp_end_ff, rsp_end_in;

   logic                          shift_en, shift_zero, win_clear, jstart, jdone, jpeak;
   logic [PRW-1:0]                jprom;
   logic [TW-1:0]                 jprom_ext;
   logic [15:0]                   prom16;
   logic                          rsp_free;
   logic signed [SAMPLE_BITS-1:0] shift_d;
   logic signed [SAMPLE_BITS-1:0] win [DEPTH];
   judge_cfg_type                 jcfg;

   function automatic logic [CNT_W-1:0] clampw(input logic [5:0] v, input int hi);
      logic [CNT_W-1:0] h;
      h = CNT_W'(hi);
      return (CNT_W'(v) > h) ? h : CNT_W'(v);
   endfunction

   assign shift_d = shift_zero ? '0 : req_sample;

   for (genvar i = 0; i < DEPTH; i++) begin : g_win
      ppf_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
         .clock    (clock),
         .clear    (reset | win_clear),
         .shift_en (shift_en),
         .d_in     ((i == DEPTH - 1) ? shift_d : win[(i == DEPTH - 1) ? i : i + 1]),
         .q        (win[i])
      );
   end

   always_comb begin
      jcfg.wl      = clampw(width_left_ff, WINDOW_MAX);
      jcfg.wr      = clampw(width_right_ff, WINDOW_MAX);
      jcfg.ds      = clampw({1'b0, mono_ff}, WINDOW_MAX - 1);
      jcfg.sl      = clampw(search_left_ff, WINDOW_MAX);
      jcfg.sr      = clampw(search_right_ff, WINDOW_MAX);
      jcfg.thr     = thr_ff;
      jcfg.floor_b = floor_ff;
      jcfg.la      = la_ff;
      jcfg.ra      = ra_ff;
   end

   ppf_judge #(.WINDOW_MAX(WINDOW_MAX), .SAMPLE_BITS(SAMPLE_BITS)) u_judge (
      .clock (clock),
      .reset (reset),
      .start (jstart),
      .cfg   (jcfg),
      .win   (win),
      .done  (jdone),
      .peak  (jpeak),
      .prom  (jprom)
   );

   assign jprom_ext = TW'(jprom);
   assign prom16    = jprom_ext[15:0];
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;

   always_comb begin
      state_in     = state_ff;
      p_in         = p_ff;
      pos_in       = pos_ff;
      la_in        = la_ff;
      ra_in        = ra_ff;
      last_in      = last_ff;
      pend_v_in    = pend_v_ff;
      pend_idx_in  = pend_idx_ff;
      pend_h_in    = pend_h_ff;
      pend_p_in    = pend_p_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_pv_in    = rsp_pv_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_h_in     = rsp_h_ff;
      rsp_p_in     = rsp_p_ff;
      rsp_end_in   = rsp_end_ff;
      shift_en     = 1'b0;
      shift_zero   = 1'b0;
      win_clear    = 1'b0;
      jstart       = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               shift_en = 1'b1;
               last_in  = req_is_last;
               p_in     = (p_ff < P_MAX) ? p_ff + 1'b1 : p_ff;
               pos_in   = p_ff - IW'(WINDOW_MAX);
               // distance from the judged slot back to position zero
               if (p_ff < IW'(2 * WINDOW_MAX + 1)) begin
                  la_in = LA_W'(p_ff) - LA_W'(WINDOW_MAX);
               end else begin
                  la_in = LA_MAX;
               end
               ra_in    = CNT_W'(WINDOW_MAX);
               state_in = S_START;
            end
         end
         S_START: begin
            jstart   = 1'b1;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (jdone) state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!last_ff) begin
               if (!jpeak) begin
                  state_in = S_IDLE;
               end else if (rsp_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_pv_in    = 1'b1;
                  rsp_idx_in   = pos_ff;
                  rsp_h_in     = win[C];
                  rsp_p_in     = prom16;
                  rsp_end_in   = 1'b0;
                  state_in     = S_IDLE;
               end
            end else if (!(jpeak && pend_v_ff && !rsp_free)) begin
               // hold one peak back so the last one can carry end of wave
               if (jpeak) begin
                  if (pend_v_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_pv_in    = 1'b1;
                     rsp_idx_in   = pend_idx_ff;
                     rsp_h_in     = pend_h_ff;
                     rsp_p_in     = pend_p_ff;
                     rsp_end_in   = 1'b0;
                  end
                  pend_v_in   = 1'b1;
                  pend_idx_in = pos_ff;
                  pend_h_in   = win[C];
                  pend_p_in   = prom16;
               end
               if (ra_ff != '0) begin
                  shift_en   = 1'b1;
                  shift_zero = 1'b1;
                  ra_in      = ra_ff - 1'b1;
                  la_in      = (la_ff == LA_MAX) ? la_ff : la_ff + 1'b1;
                  pos_in     = pos_ff + 1'b1;
                  state_in   = S_START;
               end else begin
                  state_in = S_FIN;
               end
            end
         end
         S_FIN: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_pv_in    = pend_v_ff;
               rsp_idx_in   = pend_v_ff ? pend_idx_ff : '0;
               rsp_h_in     = pend_v_ff ? pend_h_ff : '0;
               rsp_p_in     = pend_v_ff ? pend_p_ff : '0;
               rsp_end_in   = 1'b1;
               pend_v_in    = 1'b0;
               win_clear    = 1'b1;
               p_in         = '0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         p_ff            <= '0;
         last_ff         <= 1'b0;
         pend_v_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         width_left_ff   <= 6'd2;
         width_right_ff  <= 6'd2;
         mono_ff         <= 5'd0;
         thr_ff          <= 16'd10;
         search_left_ff  <= 6'd8;
         search_right_ff <= 6'd8;
         floor_ff        <= -16'sd9999;
      end else begin
         state_ff     <= state_in;
         p_ff         <= p_in;
         last_ff      <= last_in;
         pend_v_ff    <= pend_v_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            case (csr_index)
               REG_WIDTH_LEFT:     width_left_ff   <= csr_data[5:0];
               REG_WIDTH_RIGHT:    width_right_ff  <= csr_data[5:0];
               REG_MONOTONIC_SPAN: mono_ff         <= csr_data[4:0];
               REG_PROM_THRESHOLD: thr_ff          <= csr_data;
               REG_SEARCH_LEFT:    search_left_ff  <= csr_data[5:0];
               REG_SEARCH_RIGHT:   search_right_ff <= csr_data[5:0];
               REG_FLOOR_BOUND:    floor_ff        <= csr_data;
               default: begin
               end
            endcase
         end
      end
      pos_ff      <= pos_in;
      la_ff       <= la_in;
      ra_ff       <= ra_in;
      pend_idx_ff <= pend_idx_in;
      pend_h_ff   <= pend_h_in;
      pend_p_ff   <= pend_p_in;
      rsp_pv_ff   <= rsp_pv_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_h_ff    <= rsp_h_in;
      rsp_p_ff    <= rsp_p_in;
      rsp_end_ff  <= rsp_end_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_peak_valid      = rsp_pv_ff;
   assign rsp_peak_index      = rsp_idx_ff;
   assign rsp_peak_height     = rsp_h_ff;
   assign rsp_peak_prominence = rsp_p_ff;
   assign rsp_end_of_wave     = rsp_end_ff;

   a_done_in_scan: assert property (@(posedge clock) disable iff (reset)
      jdone |-> (state_ff == S_SCAN))
      else $error("judge finished outside scan");
   a_fin_emits_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && rsp_free) |=> (rsp_valid_ff && rsp_end_ff))
      else $error("end of wave beat not issued");
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_START && ra_ff == CNT_W'(WINDOW_MAX)))
      else $error("accepted beat did not start a scan");
   a_la_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (la_ff <= LA_MAX))
      else $error("left distance above window");

endmodule

// File: tb/prominence_peak_finder_tb.sv
`timescale 1ns / 100ps

module prominence_peak_finder_tb import ppf_pkg::*;;

   localparam int WIN       = 32;
   localparam int SLOTS     = 2 * WIN + 2;
   localparam int LAST_POS  = 8191;
   localparam int STALL_MAX = 10000;
   localparam int SETTLE    = 45;

   typedef struct packed {
      bit        pv;
      bit [12:0] idx;
      bit [15:0] height;
      bit [15:0] prom;
      bit        eow;
   } peak_rec_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [15:0] req_sample = '0;
   logic               req_is_last = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_peak_valid;
   logic [12:0]        rsp_peak_index;
   logic signed [15:0] rsp_peak_height;
   logic [15:0]        rsp_peak_prominence;
   logic               rsp_end_of_wave;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [2:0]         csr_index = '0;
   logic [15:0]        csr_data = '0;

   // predictor state
   int           win_buf [SLOTS];
   int           pos_count;
   int           m_wl, m_wr, m_ds, m_thr, m_sl, m_sr, m_floor;
   peak_rec_type peak_q [$];

   int  fails = 0;
   int  idle_cycles = 0;
   bit  quiet = 1'b0;
   bit  hold_rsp = 1'b0;
   int  pulse_amp = 0;

   prominence_peak_finder uut (.*);

   always #1 clock = ~clock;

   function automatic int clip(int v, int hi);
      return v > hi ? hi : v;
   endfunction

   function automatic bit judge_slot(int c, int lo, output int prom);
      int wl, wr, ds, sl, sr, mw, pk, lmin, rmin, mn, j, ls, rs;
      wl = clip(m_wl, WIN);
      wr = clip(m_wr, WIN);
      ds = clip(m_ds, WIN - 1);
      sl = clip(m_sl, WIN);
      sr = clip(m_sr, WIN);
      mw = wl > wr ? wl : wr;
      pk = win_buf[c];
      lmin = pk;
      rmin = pk;
      prom = 0;
      if (c - lo < mw || (SLOTS - 1) - c < mw) return 0;
      for (j = c - wl; j <= c + wr; j++)
         if (j != c && pk < win_buf[j]) return 0;
      for (int d = 1; d <= ds; d++) begin
         j = c - d;
         if (j >= lo && win_buf[j] > win_buf[j+1]) return 0;
         j = c + d;
         if (j + 1 <= SLOTS - 1 && win_buf[j] < win_buf[j+1]) return 0;
      end
      if (c - 1 >= lo) begin
         ls = c - 1;
         while (ls > lo && win_buf[ls] < pk && (c - ls) <= sl) ls--;
         for (j = ls; j < c; j++)
            if (win_buf[j] < lmin && win_buf[j] != 0) lmin = win_buf[j];
      end
      rs = c + 1;
      while (rs <= SLOTS - 1 && win_buf[rs] < pk && (rs - c) <= sr) rs++;
      for (j = c + 1; j < rs; j++)
         if (win_buf[j] < rmin && win_buf[j] != 0) rmin = win_buf[j];
      mn = lmin < rmin ? lmin : rmin;
      prom = (mn < m_floor) ? 0 : pk - mn;
      if (prom < m_thr) return 0;
      return 1;
   endfunction

   function automatic void predict_peaks(logic signed [15:0] x, bit last);
      int           p, lo, cend, prom;
      peak_rec_type rec;
      peak_rec_type found [$];
      p = pos_count;
      for (int k = 0; k < SLOTS - 1; k++) win_buf[k] = win_buf[k+1];
      win_buf[SLOTS-1] = x;
      if (pos_count < LAST_POS) pos_count++;
      lo = (p < SLOTS - 1) ? SLOTS - 1 - p : 0;
      cend = last ? SLOTS - 1 : WIN + 1;
      for (int c = WIN + 1; c <= cend; c++) begin
         if (judge_slot(c, lo, prom)) begin
            rec.pv = 1'b1;
            rec.idx = 13'(p - (SLOTS - 1 - c));
            rec.height = 16'(win_buf[c]);
            rec.prom = 16'(prom);
            rec.eow = 1'b0;
            found.insert(found.size(), rec);
         end
      end
      if (last) begin
         if (found.size() == 0) found.insert(0, '0);
         found[found.size()-1].eow = 1'b1;
         foreach (win_buf[k]) win_buf[k] = 0;
         pos_count = 0;
      end
      foreach (found[k]) peak_q.insert(peak_q.size(), found[k]);
   endfunction

   function automatic int sender_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 40) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic signed [15:0] next_sample();
      int r, v;
      r = $urandom_range(0, 99);
      if (r < 8) return 16'($urandom);
      if (r < 13) return '0;
      if (r < 20) pulse_amp = $urandom_range(20, 32000);
      v = pulse_amp + $urandom_range(0, 16) - 8;
      pulse_amp = pulse_amp * 2 / 3;
      if (v > 32767) v = 32767;
      return 16'(v);
   endfunction

   task automatic send_sample(logic signed [15:0] x, bit last);
      int gap;
      gap = sender_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_sample  <= x;
      req_is_last <= last;
      do @(posedge clock); while (!req_ready);
      predict_peaks(x, last);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_WIDTH_LEFT:     m_wl = val & 63;
         REG_WIDTH_RIGHT:    m_wr = val & 63;
         REG_MONOTONIC_SPAN: m_ds = val & 31;
         REG_PROM_THRESHOLD: m_thr = val;
         REG_SEARCH_LEFT:    m_sl = val & 63;
         REG_SEARCH_RIGHT:   m_sr = val & 63;
         REG_FLOOR_BOUND:    m_floor = $signed(val);
         default: ;
      endcase
   endtask

   task automatic set_cfg(int wl, int wr, int ds, int thr, int sl, int sr, int fb);
      write_reg(REG_WIDTH_LEFT, 16'(wl));
      write_reg(REG_WIDTH_RIGHT, 16'(wr));
      write_reg(REG_MONOTONIC_SPAN, 16'(ds));
      write_reg(REG_PROM_THRESHOLD, 16'(thr));
      write_reg(REG_SEARCH_LEFT, 16'(sl));
      write_reg(REG_SEARCH_RIGHT, 16'(sr));
      write_reg(REG_FLOOR_BOUND, 16'(fb));
      csr_valid <= 1'b0;
   endtask

   // block may still be judging after the last beat of a wave
   task automatic drain();
      req_valid <= 1'b0;
      while (peak_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic send_wave(int len);
      for (int k = 0; k < len; k++) send_sample(next_sample(), k == len - 1);
      drain();
   endtask

   task automatic test_directed();
      logic signed [15:0] shape [17] = '{0, 3, 20, 32767, 20, 3, -32768, 1, 1,
                                          50, 50, 1, 0, 7, 0, 40, 9};
      foreach (shape[k]) send_sample(shape[k], k == 16);
      drain();
      send_sample(16'sd123, 1'b1);
      drain();
      // zero widths and threshold let position zero be a peak
      set_cfg(0, 0, 0, 0, 8, 8, -9999);
      send_sample(16'sd500, 1'b0);
      send_sample(16'sd1, 1'b0);
      send_sample(16'sd2, 1'b1);
      drain();
   endtask

   task automatic test_extremes();
      set_cfg(32, 32, 31, 0, 32, 32, -32768);
      send_wave(70);
      set_cfg(63, 63, 31, 65535, 63, 63, 32767);
      send_wave(70);
      set_cfg(0, 0, 0, 0, 0, 0, -32768);
      send_wave(20);
      set_cfg(1, 3, 2, 100, 0, 63, 0);
      send_wave(20);
   endtask

   task automatic test_random();
      int len;
      for (int w = 0; w < 8; w++) begin
         set_cfg($urandom_range(0, 9) == 0 ? $urandom_range(0, 63) : $urandom_range(0, 4),
                 $urandom_range(0, 9) == 0 ? $urandom_range(0, 63) : $urandom_range(0, 4),
                 $urandom_range(0, 7) == 0 ? $urandom_range(0, 31) : $urandom_range(0, 2),
                 $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, 200),
                 $urandom_range(0, 40), $urandom_range(0, 40),
                 $urandom_range(0, 3) == 0 ? int'($signed(16'($urandom))) : -9999);
         quiet = (w % 7 == 3);
         len = $urandom_range(0, 9) == 0 ? $urandom_range(1, 3) :
               ($urandom_range(0, 6) == 0 ? $urandom_range(40, 70) : $urandom_range(6, 16));
         send_wave(len);
      end
      quiet = 1'b0;
   endtask

   task automatic test_backpressure();
      set_cfg(1, 1, 0, 0, 8, 8, -32768);
      hold_rsp = 1'b1;
      quiet = 1'b1;
      send_wave(40);
      quiet = 1'b0;
   endtask

   // result beats against the predicted queue
   always @(posedge clock) begin
      peak_rec_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (peak_q.size() == 0) begin
            $error("unexpected result beat, index %0d", rsp_peak_index);
            fails++;
         end else begin
            want = peak_q.pop_front();
            if (rsp_peak_valid !== want.pv) begin
               $error("peak_valid expected %0d got %0d", want.pv, rsp_peak_valid);
               fails++;
            end
            if (rsp_peak_index !== want.idx) begin
               $error("peak_index expected %0d got %0d", want.idx, rsp_peak_index);
               fails++;
            end
            if (rsp_peak_height !== want.height) begin
               $error("peak_height expected %0d got %0d",
                      $signed(want.height), rsp_peak_height);
               fails++;
            end
            if (rsp_peak_prominence !== want.prom) begin
               $error("peak_prominence expected %0d got %0d", want.prom, rsp_peak_prominence);
               fails++;
            end
            if (rsp_end_of_wave !== want.eow) begin
               $error("end_of_wave expected %0d got %0d", want.eow, rsp_end_of_wave);
               fails++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_MAX) begin
         $display("FAIL");
         $finish;
      end
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      int r;
      forever begin
         @(posedge clock);
         r = $urandom_range(0, 99);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (quiet || r < 70) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b0;
            if (r < 95) repeat ($urandom_range(0, 4)) @(posedge clock);
            else repeat ($urandom_range(10, 60)) @(posedge clock);
         end
      end
   end

   initial begin
      foreach (win_buf[k]) win_buf[k] = 0;
      pos_count = 0;
      m_wl = 2;
      m_wr = 2;
      m_ds = 0;
      m_thr = 10;
      m_sl = 8;
      m_sr = 8;
      m_floor = -9999;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_extremes();
      test_random();
      test_backpressure();
      if (fails == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
